### design/sobv_pkg.sv
// Shared types and constants for the vertical Sobel gradient block.
`timescale 1ns / 1ps

package sobv_pkg;

    localparam int IMAGE_WIDTH  = 512;
    localparam int IMAGE_HEIGHT = 512;

    localparam int PIXEL_W = 8;
    localparam int COL_W   = $clog2(IMAGE_WIDTH);
    localparam int ROW_W   = $clog2(IMAGE_HEIGHT);

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(IMAGE_WIDTH - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(IMAGE_HEIGHT - 1);
    localparam logic [COL_W-1:0] FIRST_INNER_COL = COL_W'(2);
    localparam logic [ROW_W-1:0] FIRST_INNER_ROW = ROW_W'(2);

    typedef logic [PIXEL_W-1:0] pixel_t;
    typedef logic [COL_W-1:0]   col_t;
    typedef logic [ROW_W-1:0]   row_t;

    typedef struct packed {
        pixel_t above;
        pixel_t middle;
    } lb_word_t;

    typedef struct packed {
        pixel_t magnitude;
        logic   saturated;
    } kern_res_t;

endpackage

### design/sobv_if.sv
// Handshake channel interfaces for pixel items and gradient result items.
`timescale 1ns / 1ps

interface sobv_pixel_if;
    logic            valid;
    logic            ready;
    sobv_pkg::pixel_t pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface sobv_result_if;
    logic             valid;
    logic             ready;
    sobv_pkg::pixel_t magnitude;
    logic             saturated;
    logic             last_in_frame;

    modport source (output valid, output magnitude, output saturated,
                    output last_in_frame, input ready);
    modport sink   (input valid, input magnitude, input saturated,
                    input last_in_frame, output ready);
endinterface

### design/sobel_vertical_gradient_3x3_core.sv
// Top level of the streaming 3x3 vertical Sobel gradient filter.
//
//  channel | direction | payload                              | handshake
//  pix     | in        | pixel                                | valid/ready
//  res     | out       | magnitude, saturated, last_in_frame  | valid/ready
//
// One pixel item per cycle sustained while res is ready; a taken pixel
// passes the line buffer read stage, then the result register.
// The single line buffer memory port pair sets the one-item-per-cycle rate.
// Reset clears the raster counters, the window and the valid flags; the line
// buffers are not cleared, as the border rows that read them give no result.
// A stall on res holds the result register and backs up into pix.ready.
`timescale 1ns / 1ps

module sobel_vertical_gradient_3x3_core
(
    input  logic               clk,
    input  logic               rst_n,
    sobv_pixel_if.sink         pix,
    sobv_result_if.source      res
);

    logic              accept;
    logic              adv;

    sobv_pkg::col_t    col_reg;
    sobv_pkg::col_t    col_next;
    sobv_pkg::row_t    row_reg;
    sobv_pkg::row_t    row_next;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    sobv_pkg::pixel_t  s1_pixel_reg;
    sobv_pkg::col_t    s1_col_reg;
    logic              s1_produce_reg;
    logic              s1_last_reg;

    sobv_pkg::lb_word_t lb_rd;
    sobv_pkg::lb_word_t lb_wr;

    sobv_pkg::pixel_t  top_win_reg [3];
    sobv_pkg::pixel_t  bot_win_reg [3];
    sobv_pkg::pixel_t  kern_top [3];
    sobv_pkg::pixel_t  kern_bot [3];
    sobv_pkg::kern_res_t kern_res;

    logic              res_valid_reg;
    logic              res_valid_next;
    sobv_pkg::pixel_t  res_mag_reg;
    logic              res_sat_reg;
    logic              res_last_reg;

    assign adv        = s1_valid_reg && (!res_valid_reg || res.ready);
    assign pix.ready  = !s1_valid_reg || adv;
    assign accept     = pix.valid && pix.ready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_reg == sobv_pkg::LAST_COL)
            begin
                col_next = '0;
                row_next = (row_reg == sobv_pkg::LAST_ROW) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Read stage: hold the item while the line buffer read completes.
    assign s1_valid_next = accept || (s1_valid_reg && !adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg   <= pix.pixel;
            s1_col_reg     <= col_reg;
            s1_produce_reg <= (row_reg >= sobv_pkg::FIRST_INNER_ROW) &&
                              (col_reg >= sobv_pkg::FIRST_INNER_COL);
            s1_last_reg    <= (row_reg == sobv_pkg::LAST_ROW) &&
                              (col_reg == sobv_pkg::LAST_COL);
        end
    end

    assign lb_wr.above  = lb_rd.middle;
    assign lb_wr.middle = s1_pixel_reg;

    sobv_linebuf u_linebuf
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (lb_rd),
        .wr_en   (adv),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wr)
    );

    // Advance the window by one column as the item leaves the read stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                top_win_reg[i] <= '0;
                bot_win_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            top_win_reg[0] <= top_win_reg[1];
            top_win_reg[1] <= top_win_reg[2];
            top_win_reg[2] <= lb_rd.above;
            bot_win_reg[0] <= bot_win_reg[1];
            bot_win_reg[1] <= bot_win_reg[2];
            bot_win_reg[2] <= s1_pixel_reg;
        end
    end

    always_comb
    begin
        kern_top[0] = top_win_reg[1];
        kern_top[1] = top_win_reg[2];
        kern_top[2] = lb_rd.above;
        kern_bot[0] = bot_win_reg[1];
        kern_bot[1] = bot_win_reg[2];
        kern_bot[2] = s1_pixel_reg;
    end

    sobv_kernel u_kernel
    (
        .top    (kern_top),
        .bot    (kern_bot),
        .result (kern_res)
    );

    always_comb
    begin
        priority if (adv)
        begin
            res_valid_next = s1_produce_reg;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_produce_reg)
        begin
            res_mag_reg  <= kern_res.magnitude;
            res_sat_reg  <= kern_res.saturated;
            res_last_reg <= s1_last_reg;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.magnitude     = res_mag_reg;
    assign res.saturated     = res_sat_reg;
    assign res.last_in_frame = res_last_reg;

`ifndef SYNTH
    a_lb_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && adv) |-> (col_reg != s1_col_reg))
        else $error("line buffer read and write hit the same column");

    a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.saturated) |-> (res.magnitude == 8'hFF))
        else $error("saturated result not clipped to full scale");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && row_reg == sobv_pkg::LAST_ROW && col_reg == sobv_pkg::LAST_COL)
        |=> (row_reg == '0 && col_reg == '0))
        else $error("raster counters did not wrap at frame end");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res.ready) |-> !adv)
        else $error("stalled result overwritten");
`endif

endmodule

### design/sobv_linebuf.sv
// Dual line buffer: one memory holding the two previous rows per column.
`timescale 1ns / 1ps

module sobv_linebuf
(
    input  logic               clk,
    input  logic               rd_en,
    input  sobv_pkg::col_t     rd_addr,
    output sobv_pkg::lb_word_t rd_data,
    input  logic               wr_en,
    input  sobv_pkg::col_t     wr_addr,
    input  sobv_pkg::lb_word_t wr_data
);

    sobv_pkg::lb_word_t mem [sobv_pkg::IMAGE_WIDTH];
    sobv_pkg::lb_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/sobv_kernel.sv
// Vertical Sobel kernel: weighted row difference, absolute value and clip.
`timescale 1ns / 1ps

module sobv_kernel
(
    input  sobv_pkg::pixel_t  top [3],
    input  sobv_pkg::pixel_t  bot [3],
    output sobv_pkg::kern_res_t result
);

    logic [9:0]        top_sum;
    logic [9:0]        bot_sum;
    logic signed [10:0] diff;
    logic [9:0]        abs_val;
    logic              sat;

    always_comb
    begin
        top_sum = {2'b00, top[0]} + {1'b0, top[1], 1'b0} + {2'b00, top[2]};
        bot_sum = {2'b00, bot[0]} + {1'b0, bot[1], 1'b0} + {2'b00, bot[2]};
        diff    = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
        abs_val = diff[10] ? 10'(-diff) : diff[9:0];
        sat     = |abs_val[9:8];
        result.magnitude = sat ? 8'hFF : abs_val[7:0];
        result.saturated = sat;
    end

endmodule
